// ----- rtl/dprq_pkg.sv -----
// ----------------------------------------------------------------------------
// dprq_pkg
// Shared types and constants for the dynamic priority ready queue: request and
// result structs, slot entry, slot store commands and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dprq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 8;
	localparam int PRI_W       = 8;
	localparam int RUN_W       = 16;
	localparam int ID_SPACE    = 1 << ID_W;

	// request kinds
	localparam logic KIND_CREATE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_CREATED   = 3'd0;
	localparam logic [2:0] STAT_RAN       = 3'd1;
	localparam logic [2:0] STAT_DUPLICATE = 3'd2;
	localparam logic [2:0] STAT_ZERO_TIME = 3'd3;
	localparam logic [2:0] STAT_FULL      = 3'd4;
	localparam logic [2:0] STAT_EMPTY     = 3'd5;

	typedef struct packed {
		logic             kind;
		logic [ID_W-1:0]  task_id;
		logic [PRI_W-1:0] priority_req;
		logic [RUN_W-1:0] run_time;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [ID_W-1:0]  ran_id;
		logic [PRI_W-1:0] new_priority;
		logic [RUN_W-1:0] time_left;
		logic             finished;
		logic [3:0]       queue_count;
	} out_item_t;

	// one queued task
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic [RUN_W-1:0] run;
	} entry_t;

	// commands from the sequencer to the slot store
	typedef struct packed {
		logic             pop;
		logic             ins;
		logic [IDX_W-1:0] pos;
		entry_t           data;
	} slot_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/dprq_slots.sv -----
// ----------------------------------------------------------------------------
// dprq_slots
// Sorted slot store: head in slot 0, pop shifts every entry forward, insert
// opens a gap at the given position. Also gives the priority at a scan index.
// ----------------------------------------------------------------------------
`default_nettype none

module dprq_slots
	import dprq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slot_cmd_t        cmd,
	input  wire logic [IDX_W-1:0] scan_idx,
	output      entry_t           head,
	output      logic [PRI_W-1:0] scan_pri,
	output      logic [CNT_W-1:0] count
);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q;

	// entry storage, no reset: only occupied slots are read
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cmd.pop) begin
				if (i < QUEUE_DEPTH - 1) begin
					slot_q[i] <= slot_q[i + 1];
				end
			end else if (cmd.ins) begin
				if (IDX_W'(i) == cmd.pos) begin
					slot_q[i] <= cmd.data;
				end else if (IDX_W'(i) > cmd.pos) begin
					slot_q[i] <= slot_q[i - 1];
				end
			end
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.pop) begin
			count_q <= count_q - 1'b1;
		end else if (cmd.ins) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign head     = slot_q[0];
	assign scan_pri = slot_q[scan_idx].pri;
	assign count    = count_q;

endmodule

`default_nettype wire

// ----- rtl/dynamic_priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// dynamic_priority_ready_queue
// Ready queue sorted by priority, highest first, with create and tick requests.
// ----------------------------------------------------------------------------
// A refused create, a tick on an empty queue or a tick whose task finishes goes
// straight from idle to done; an insert first walks the slots in order with the
// single priority comparator until it finds its place. The result register loads
// in done once the output is free, and a new request is taken only back in idle.
// Reset clears the queue occupancy, the seen-id map and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_priority_ready_queue
	import dprq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire in_item_t  in_item,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      out_item_t out_item
);

	state_t           state_q, state_d;
	logic [ID_SPACE-1:0] seen_q;
	logic [IDX_W-1:0] idx_q;
	logic             after_eq_q;
	entry_t           task_q;
	out_item_t        res_q;
	logic             out_valid_q;
	out_item_t        out_item_q;

	slot_cmd_t        cmd;
	entry_t           head;
	logic [PRI_W-1:0] scan_pri;
	logic [CNT_W-1:0] count;

	logic             accept;
	logic             is_full;
	logic             is_empty;
	logic             scan_hit;
	logic             scan_end;
	logic             scan_stop;
	logic             load_out;
	logic [PRI_W-1:0] hp_dec;
	logic [RUN_W-1:0] ht_dec;
	out_item_t        res_d;
	out_item_t        out_d;

	dprq_slots u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.scan_idx (idx_q),
		.head     (head),
		.scan_pri (scan_pri),
		.count    (count)
	);

	// shared compare unit and decrements
	always_comb begin
		accept    = in_valid && in_ready;
		is_full   = (count == CNT_W'(QUEUE_DEPTH));
		is_empty  = (count == '0);
		scan_hit  = after_eq_q ? (task_q.pri > scan_pri) : (task_q.pri >= scan_pri);
		scan_end  = (CNT_W'(idx_q) == count);
		scan_stop = scan_end || scan_hit;
		hp_dec    = (head.pri != '0) ? head.pri - 1'b1 : head.pri;
		ht_dec    = (head.run != '0) ? head.run - 1'b1 : head.run;
		load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// result fields of the accepted request and the outgoing result
	always_comb begin
		res_d = '0;
		if (in_item.kind == KIND_CREATE) begin
			if (is_full) begin
				res_d.status = STAT_FULL;
			end else if (seen_q[in_item.task_id]) begin
				res_d.status = STAT_DUPLICATE;
			end else if (in_item.run_time == '0) begin
				res_d.status = STAT_ZERO_TIME;
			end else begin
				res_d.status = STAT_CREATED;
			end
		end else if (is_empty) begin
			res_d.status = STAT_EMPTY;
		end else begin
			res_d.status       = STAT_RAN;
			res_d.ran_id       = head.id;
			res_d.new_priority = hp_dec;
			res_d.time_left    = ht_dec;
			res_d.finished     = (ht_dec == '0);
		end
		out_d             = res_q;
		out_d.queue_count = 4'(count);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.kind == KIND_CREATE) begin
						if (!is_full && !seen_q[in_item.task_id] && in_item.run_time != '0) begin
							state_d = ST_SCAN;
						end else begin
							state_d = ST_DONE;
						end
					end else if (!is_empty && ht_dec != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_stop) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd      = '0;
		cmd.pos  = idx_q;
		cmd.data = task_q;
		unique case (state_q)
			ST_IDLE: cmd.pop = accept && (in_item.kind == KIND_TICK) && !is_empty;
			ST_SCAN: cmd.ins = scan_stop;
			ST_DONE: cmd     = cmd;
			default: cmd     = cmd;
		endcase
	end

	// seen-id map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept && in_item.kind == KIND_CREATE && !is_full) begin
			seen_q[in_item.task_id] <= 1'b1;
		end
	end

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working task, scan index and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= '0;
			res_q <= res_d;
			if (in_item.kind == KIND_CREATE) begin
				after_eq_q <= 1'b1;
				task_q.id  <= in_item.task_id;
				task_q.pri <= in_item.priority_req;
				task_q.run <= in_item.run_time;
			end else begin
				after_eq_q <= 1'b0;
				task_q.id  <= head.id;
				task_q.pri <= hp_dec;
				task_q.run <= ht_dec;
			end
		end else if (state_q == ST_SCAN && !scan_stop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_item_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

// ----- test/tb_dynamic_priority_ready_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dynamic_priority_ready_queue
// Self-checking bench for the priority ready queue. A short table of directed
// requests covers the empty queue, refused creates, the full queue and ties of
// priority. About 800 random requests follow, biased towards runnable tasks.
// Every result is checked field by field, against the table or else a behavioural
// queue model, with random gaps on the request side and random result stalls.
// ----------------------------------------------------------------------------

module tb_dynamic_priority_ready_queue;
	import dprq_pkg::*;

	localparam int RANDOM_REQUESTS = 800;

	typedef struct packed {
		in_item_t  req;
		logic      typed;
		out_item_t want;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// behavioural copy of the queue, head in slot 0
	logic [ID_W-1:0]  pq_id  [QUEUE_DEPTH];
	logic [PRI_W-1:0] pq_pri [QUEUE_DEPTH];
	logic [RUN_W-1:0] pq_run [QUEUE_DEPTH];
	int               pq_len = 0;
	bit               id_seen [ID_SPACE];

	out_item_t expected_results[$];
	stim_row_t directed_rows[$];
	int        mismatches = 0;
	int        status_count[8];
	int        finished_count = 0;
	bit        no_idle = 1'b0;
	int        hold_cycles = 0;

	dynamic_priority_ready_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// slot insert with shift towards the tail
	function automatic void queue_insert(input int pos, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri, input logic [RUN_W-1:0] run);
		for (int i = pq_len; i > pos; i--) begin
			pq_id[i]  = pq_id[i-1];
			pq_pri[i] = pq_pri[i-1];
			pq_run[i] = pq_run[i-1];
		end
		pq_id[pos]  = id;
		pq_pri[pos] = pri;
		pq_run[pos] = run;
		pq_len++;
	endfunction

	// advance the queue model by one request and return its result
	function automatic out_item_t predict_result(input in_item_t req);
		out_item_t        r;
		logic [ID_W-1:0]  hid;
		logic [PRI_W-1:0] hp;
		logic [RUN_W-1:0] ht;
		int               pos;
		r = '0;
		if (req.kind == KIND_CREATE) begin
			if (pq_len >= QUEUE_DEPTH) begin
				r.status = STAT_FULL;
			end else if (id_seen[req.task_id]) begin
				r.status = STAT_DUPLICATE;
			end else begin
				id_seen[req.task_id] = 1'b1;
				if (req.run_time == '0) begin
					r.status = STAT_ZERO_TIME;
				end else begin
					// new task goes behind equal priorities
					pos = 0;
					while (pos < pq_len && req.priority_req <= pq_pri[pos])
						pos++;
					queue_insert(pos, req.task_id, req.priority_req, req.run_time);
					r.status = STAT_CREATED;
				end
			end
		end else if (pq_len == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			hid = pq_id[0];
			hp  = pq_pri[0];
			ht  = pq_run[0];
			for (int i = 1; i < pq_len; i++) begin
				pq_id[i-1]  = pq_id[i];
				pq_pri[i-1] = pq_pri[i];
				pq_run[i-1] = pq_run[i];
			end
			pq_len--;
			if (hp != '0)
				hp = hp - 1'b1;
			if (ht != '0)
				ht = ht - 1'b1;
			if (ht != '0) begin
				// requeued task goes ahead of equal priorities
				pos = 0;
				while (pos < pq_len && hp < pq_pri[pos])
					pos++;
				queue_insert(pos, hid, hp, ht);
			end else begin
				r.finished = 1'b1;
			end
			r.status       = STAT_RAN;
			r.ran_id       = hid;
			r.new_priority = hp;
			r.time_left    = ht;
		end
		r.queue_count = 4'(pq_len);
		return r;
	endfunction

	function automatic in_item_t make_req(input logic kind, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri, input logic [RUN_W-1:0] run);
		in_item_t r;
		r.kind         = kind;
		r.task_id      = id;
		r.priority_req = pri;
		r.run_time     = run;
		return r;
	endfunction

	// result with only status and count set
	function automatic out_item_t plain_result(input logic [2:0] st, input logic [3:0] cnt);
		out_item_t r;
		r             = '0;
		r.status      = st;
		r.queue_count = cnt;
		return r;
	endfunction

	function automatic void add_row(input in_item_t req, input logic typed,
			input out_item_t want);
		stim_row_t row;
		row.req   = req;
		row.typed = typed;
		row.want  = want;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// present one request after a random gap, record its expected result on accept
	task automatic send_request(input in_item_t req, input logic typed,
			input out_item_t want);
		int        gap;
		out_item_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = predict_result(req);
		expected_results.insert(expected_results.size(), typed ? want : predicted);
	endtask

	// result side: random stalls and field-by-field check
	always @(posedge clk) begin
		out_item_t want;
		bit        bad;
		if (!arst_n) begin
			out_ready   <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h",
						$time, out_item);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					bad  = 1'b0;
					if (out_item.status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, out_item.status);
						bad = 1'b1;
					end
					if (out_item.ran_id !== want.ran_id) begin
						$display("%0t: ran_id expected %0d, actual %0d",
							$time, want.ran_id, out_item.ran_id);
						bad = 1'b1;
					end
					if (out_item.new_priority !== want.new_priority) begin
						$display("%0t: new_priority expected %0d, actual %0d",
							$time, want.new_priority, out_item.new_priority);
						bad = 1'b1;
					end
					if (out_item.time_left !== want.time_left) begin
						$display("%0t: time_left expected %0d, actual %0d",
							$time, want.time_left, out_item.time_left);
						bad = 1'b1;
					end
					if (out_item.finished !== want.finished) begin
						$display("%0t: finished expected %0d, actual %0d",
							$time, want.finished, out_item.finished);
						bad = 1'b1;
					end
					if (out_item.queue_count !== want.queue_count) begin
						$display("%0t: queue_count expected %0d, actual %0d",
							$time, want.queue_count, out_item.queue_count);
						bad = 1'b1;
					end
					if (bad)
						mismatches++;
					status_count[want.status]++;
					if (want.finished)
						finished_count++;
				end
				hold_cycles = no_idle ? 0 : $urandom_range(0, 17);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		in_item_t         req;
		int               tick_pct;
		int               roll;
		int               start;
		logic [ID_W-1:0]  pick;
		logic [PRI_W-1:0] pri;
		logic [RUN_W-1:0] run;
		bit               found;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty queue, refusals, fill to full, ties, finish
		add_row(make_req(KIND_TICK, 8'd0, 8'd0, 16'd0), 1'b1, plain_result(STAT_EMPTY, 4'd0));
		add_row(make_req(KIND_CREATE, 8'd0, 8'd0, 16'd0), 1'b1,
			plain_result(STAT_ZERO_TIME, 4'd0));
		add_row(make_req(KIND_CREATE, 8'd0, 8'd255, 16'hFFFF), 1'b1,
			plain_result(STAT_DUPLICATE, 4'd0));
		add_row(make_req(KIND_CREATE, 8'd255, 8'd255, 16'hFFFF), 1'b1,
			plain_result(STAT_CREATED, 4'd1));
		add_row(make_req(KIND_CREATE, 8'd1, 8'd0, 16'd1), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd2, 8'd255, 16'd1), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd7, 8'd255, 16'd2), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd3, 8'd128, 16'd2), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd6, 8'h55, 16'h5555), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd5, 8'd1, 16'hAAAA), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd4, 8'd0, 16'd3), 1'b0, '0);
		add_row(make_req(KIND_CREATE, 8'd8, 8'hAA, 16'd7), 1'b1, plain_result(STAT_FULL, 4'd8));
		add_row(make_req(KIND_TICK, 8'hFF, 8'hFF, 16'hFFFF), 1'b0, '0);
		add_row(make_req(KIND_TICK, 8'd0, 8'd0, 16'd0), 1'b0, '0);
		// an id refused while full is still free
		add_row(make_req(KIND_CREATE, 8'd8, 8'hAA, 16'd7), 1'b0, '0);
		repeat (5)
			add_row(make_req(KIND_TICK, 8'd0, 8'd0, 16'd0), 1'b0, '0);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		// random part, ticks weighted by queue fill so tasks keep draining
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if ($urandom_range(0, 59) == 0)
				no_idle = !no_idle;
			if (n == 250 || n == 550) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (expected_results.size() != 0);
			end
			tick_pct = (pq_len == 0) ? 20 : (pq_len >= QUEUE_DEPTH - 1) ? 85 : 70;
			roll     = $urandom_range(0, 99);
			req      = make_req(KIND_TICK, ID_W'($urandom), PRI_W'($urandom),
				RUN_W'($urandom));
			if (roll >= tick_pct) begin
				// mostly fresh ids, some repeats
				pick  = ID_W'($urandom);
				found = 1'b0;
				if ($urandom_range(0, 7) != 0) begin
					start = $urandom_range(0, ID_SPACE - 1);
					for (int k = 0; k < ID_SPACE; k++) begin
						if (!found && !id_seen[(start + k) % ID_SPACE]) begin
							pick  = ID_W'((start + k) % ID_SPACE);
							found = 1'b1;
						end
					end
				end
				// priorities: random, extremes or a tie with a queued task
				roll = $urandom_range(0, 9);
				if (roll < 3 && pq_len > 0)
					pri = pq_pri[$urandom_range(0, pq_len - 1)];
				else if (roll < 5)
					pri = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom_range(0, 2)) :
						PRI_W'($urandom_range(253, 255));
				else
					pri = PRI_W'($urandom);
				// run times kept short so tasks finish
				roll = $urandom_range(0, 99);
				if (roll < 70)
					run = RUN_W'($urandom_range(1, 4));
				else if (roll < 93)
					run = RUN_W'($urandom_range(5, 24));
				else if (roll < 99)
					run = '0;
				else
					run = RUN_W'($urandom_range(25, 65535));
				req = make_req(KIND_CREATE, pick, pri, run);
			end
			send_request(req, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain, then allow for the longest insert walk
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (QUEUE_DEPTH + 4) @(posedge clk);

		$display("covered %0d created, %0d ran (%0d to completion), %0d ticks on empty queue",
			status_count[STAT_CREATED], status_count[STAT_RAN], finished_count,
			status_count[STAT_EMPTY]);
		$display("refused creates: %0d duplicate id, %0d zero time, %0d queue full",
			status_count[STAT_DUPLICATE], status_count[STAT_ZERO_TIME],
			status_count[STAT_FULL]);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
